FILE: design/lzss_stream_encoder_core_assert.svh
// ----------------------------------------------------------------------------
// LZSS encoder assertion macros
// Shared property forms for the port checker.
// ----------------------------------------------------------------------------
`ifndef LZSS_STREAM_ENCODER_CORE_ASSERT_SVH
`define LZSS_STREAM_ENCODER_CORE_ASSERT_SVH

// Same-cycle implication, sampled on clk, off during reset.
`define LZSS_ASSERT_NOW(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// Next-cycle implication, sampled on clk, off during reset.
`define LZSS_ASSERT_NEXT(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

FILE: design/lzss_pkg.sv
// ----------------------------------------------------------------------------
// LZSS encoder package
// Payload types and fixed constants shared by the encoder modules.
// ----------------------------------------------------------------------------
package lzss_pkg;

	// Raw input transaction
	typedef struct packed {
		logic [7:0] data_byte;
		logic       end_of_stream;
	} lzss_in_t;

	// Code output transaction
	typedef struct packed {
		logic [7:0] code_byte;
		logic       last_byte;
	} lzss_out_t;

	// Control from the coding engine to the output queue
	typedef struct packed {
		logic       push;
		logic [7:0] push_byte;
		logic       release_step;
	} lzss_oq_ctl_t;

	localparam int LEN_W    = 5;   // match lengths and lookahead counts
	localparam int QAW      = 7;   // output queue address width
	localparam int QDEPTH   = 128;
	localparam logic [QAW:0] RESULT_LIMIT = 8'd29;
	localparam logic [QAW:0] QROOM        = 8'd64;
	localparam logic [7:0]   FILL_CHAR    = 8'h20;

endpackage

FILE: design/lzss_oq.sv
// ----------------------------------------------------------------------------
// LZSS output queue
// Holds coded bytes, releases them in per-transaction batches and presents
// them on the output register with the last mark on each batch end.
// ----------------------------------------------------------------------------
module lzss_oq
	import lzss_pkg::*;
(
	input  logic         clk,
	input  logic         arst_n,
	input  lzss_oq_ctl_t ctl,
	output logic         room,
	output logic         code_valid,
	input  logic         code_stall,
	output lzss_out_t    code
);

	logic [7:0]     mem [QDEPTH];
	logic [QDEPTH-1:0] lastf_q;
	logic [QAW-1:0] head_q, tail_q, mark_idx;
	logic [QAW:0]   cnt_q, pend_q, rel_q, rel_n;
	logic           fetch_q, ov_q, last_s, issue;
	logic [7:0]     rd_q;

	// batch size and index of its final byte
	assign rel_n    = (pend_q < RESULT_LIMIT) ? pend_q : RESULT_LIMIT;
	assign mark_idx = tail_q - pend_q[QAW-1:0] + rel_n[QAW-1:0] - 1'b1;
	assign issue    = (rel_q != '0) && !fetch_q && !ov_q;
	assign room     = (cnt_q <= QROOM);

	// storage and registered read
	always_ff @(posedge clk) begin
		if (ctl.push)
			mem[tail_q] <= ctl.push_byte;
		if (issue)
			rd_q <= mem[head_q];
	end

	// pointers, counts and batch marks
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			head_q  <= '0;
			tail_q  <= '0;
			cnt_q   <= '0;
			pend_q  <= '0;
			rel_q   <= '0;
			lastf_q <= '0;
			fetch_q <= 1'b0;
			ov_q    <= 1'b0;
			last_s  <= 1'b0;
		end else begin
			if (issue) begin
				last_s           <= lastf_q[head_q];
				lastf_q[head_q]  <= 1'b0;
				head_q           <= head_q + 1'b1;
			end
			if (ctl.release_step && rel_n != '0)
				lastf_q[mark_idx] <= 1'b1;
			if (ctl.push)
				tail_q <= tail_q + 1'b1;
			cnt_q  <= cnt_q + {{QAW{1'b0}}, ctl.push} - {{QAW{1'b0}}, issue};
			pend_q <= pend_q + {{QAW{1'b0}}, ctl.push}
				- (ctl.release_step ? rel_n : '0);
			rel_q  <= rel_q + (ctl.release_step ? rel_n : '0) - {{QAW{1'b0}}, issue};
			fetch_q <= issue;
			if (fetch_q)
				ov_q <= 1'b1;
			else if (ov_q && !code_stall)
				ov_q <= 1'b0;
		end
	end

	assign code_valid     = ov_q;
	assign code.code_byte = rd_q;
	assign code.last_byte = last_s;

endmodule

FILE: design/lzss_stream_encoder_core.sv
// ----------------------------------------------------------------------------
// LZSS stream encoder core
// 4096-byte ring window, matches of 3 to 18 bytes, flag-led groups of eight.
// ----------------------------------------------------------------------------
// One byte is taken per transaction and the block then stalls its input while
// it codes. A byte that completes the lookahead starts a unit search: each
// candidate position behind the coding point is compared byte by byte (a
// registered read of the window memory, then a compare), over up to
// WINDOW_SIZE-1 candidates; bytes inside a match skip the search.
// Every emitted group goes into the output queue byte by byte, flag byte first.
// After reset and after each end-of-stream byte a clearing pass over all
// WINDOW_SIZE entries rewrites the window and source map, with the input
// stalled. Coded bytes queue up and leave through a registered read and an
// output register; the queue is read only while that register is empty.
module lzss_stream_encoder_core
	import lzss_pkg::*;
#(
	parameter int WINDOW_SIZE         = 4096,
	parameter int MAX_MATCH           = 18,
	parameter int MIN_MATCH_MINUS_ONE = 2
) (
	input  logic      clk,
	input  logic      arst_n,
	input  logic      item_valid,
	output logic      item_stall,
	input  lzss_in_t  item,
	output logic      code_valid,
	input  logic      code_stall,
	output lzss_out_t code
);

	localparam int AW  = $clog2(WINDOW_SIZE);
	localparam int NW  = $clog2(MAX_MATCH);
	localparam int CAP = (MAX_MATCH < MIN_MATCH_MINUS_ONE + 16) ?
		MAX_MATCH : MIN_MATCH_MINUS_ONE + 16;
	localparam logic [AW:0]      WIN    = (AW+1)'(WINDOW_SIZE);
	localparam logic [AW-1:0]    WLAST  = AW'(WINDOW_SIZE - 1);
	localparam logic [AW-1:0]    WSTART = AW'(WINDOW_SIZE - MAX_MATCH);
	localparam logic [AW-1:0]    MAPLO  = AW'(WINDOW_SIZE - 2 * MAX_MATCH);
	localparam logic [AW-1:0]    MAXA   = AW'(MAX_MATCH);
	localparam logic [LEN_W-1:0] MAXL   = LEN_W'(MAX_MATCH);
	localparam logic [LEN_W-1:0] CAPL   = LEN_W'(CAP);
	localparam logic [LEN_W-1:0] MINL   = LEN_W'(MIN_MATCH_MINUS_ONE);

	localparam logic [3:0] ST_CLR  = 4'd0;
	localparam logic [3:0] ST_IDLE = 4'd1;
	localparam logic [3:0] ST_CHK  = 4'd2;
	localparam logic [3:0] ST_ISS  = 4'd3;
	localparam logic [3:0] ST_EVAL = 4'd4;
	localparam logic [3:0] ST_EMIT = 4'd5;
	localparam logic [3:0] ST_SEND = 4'd6;
	localparam logic [3:0] ST_ADVC = 4'd7;
	localparam logic [3:0] ST_ADV  = 4'd8;
	localparam logic [3:0] ST_REL  = 4'd9;

	function automatic logic [AW-1:0] wrap_add(logic [AW-1:0] a, logic [AW-1:0] b);
		logic [AW:0] s;
		s = {1'b0, a} + {1'b0, b};
		if (s >= WIN)
			s = s - WIN;
		return s[AW-1:0];
	endfunction

	logic [3:0]       state_q;
	logic [AW-1:0]    clr_idx_q, wp_q, cand_q, d_q, bpos_q;
	logic [LEN_W-1:0] la_q, skip_q, n_q, best_q, limit_q, hit_len, new_best;
	logic [7:0]       flags_q;
	logic [2:0]       gunits_q;
	logic [4:0]       gfill_q, send_idx_q, sidx_m1;
	logic [7:0]       gbuf_q [16];
	logic [7:0]       lah_q [MAX_MATCH];
	logic             end_q, drain_q, flush_q, accept, hit, unit_due;
	logic [11:0]      pos12;
	lzss_oq_ctl_t     oq_ctl;
	logic             oq_room;

	// window and source map memories
	logic [7:0]    ring [WINDOW_SIZE];
	logic          srcmap [WINDOW_SIZE];
	logic          ring_we, map_we, map_wd, map_rd_q;
	logic [AW-1:0] ring_wa, ring_ra, map_wa;
	logic [7:0]    ring_wd, ring_rd_q;

	assign accept     = item_valid && !item_stall;
	assign item_stall = (state_q != ST_IDLE) || !oq_room;
	assign unit_due   = (la_q == MAXL && !drain_q) || (drain_q && la_q != '0);
	assign hit        = map_rd_q && (ring_rd_q == lah_q[n_q[NW-1:0]]);
	assign hit_len    = hit ? n_q + 1'b1 : n_q;
	assign new_best   = (hit_len > best_q) ? hit_len : best_q;
	assign sidx_m1    = send_idx_q - 1'b1;
	assign pos12      = 12'(bpos_q);

	// memory port selection
	always_comb begin
		ring_we = 1'b0;
		ring_wa = wrap_add(wp_q, AW'(la_q));
		ring_wd = item.data_byte;
		map_we  = 1'b0;
		map_wa  = wrap_add(wp_q, AW'(la_q));
		map_wd  = 1'b0;
		ring_ra = wrap_add(cand_q, AW'(n_q));
		unique case (state_q)
			ST_CLR: begin
				ring_we = 1'b1;
				ring_wa = clr_idx_q;
				ring_wd = FILL_CHAR;
				map_we  = 1'b1;
				map_wa  = clr_idx_q;
				map_wd  = (clr_idx_q >= MAPLO) && (clr_idx_q < WSTART);
			end
			ST_IDLE: begin
				ring_we = accept && (la_q < MAXL);
				map_we  = accept && (la_q < MAXL);
			end
			ST_ADVC: begin
				map_we = 1'b1;
				map_wa = wrap_add(wp_q, MAXA);
			end
			ST_ADV: begin
				map_we = 1'b1;
				map_wa = wp_q;
				map_wd = 1'b1;
			end
			default: begin
			end
		endcase
	end

	always_ff @(posedge clk) begin
		if (ring_we)
			ring[ring_wa] <= ring_wd;
		ring_rd_q <= ring[ring_ra];
	end

	always_ff @(posedge clk) begin
		if (map_we)
			srcmap[map_wa] <= map_wd;
		map_rd_q <= srcmap[cand_q];
	end

	// lookahead copy and group buffer
	always_ff @(posedge clk) begin
		if (state_q == ST_IDLE && accept && la_q < MAXL)
			lah_q[la_q[NW-1:0]] <= item.data_byte;
		if (state_q == ST_ADV) begin
			for (int i = 0; i < MAX_MATCH - 1; i++)
				lah_q[i] <= lah_q[i+1];
		end
		if (state_q == ST_EMIT) begin
			if (best_q <= MINL) begin
				if (gfill_q < 5'd16)
					gbuf_q[gfill_q[3:0]] <= lah_q[0];
			end else if (gfill_q <= 5'd14) begin
				gbuf_q[gfill_q[3:0]]        <= bpos_q[7:0];
				gbuf_q[gfill_q[3:0] + 1'b1] <= {pos12[11:8], 4'(best_q - MINL - 1'b1)};
			end
		end
	end

	// output queue control
	always_comb begin
		oq_ctl.push         = (state_q == ST_SEND);
		oq_ctl.push_byte    = (send_idx_q == '0) ? flags_q : gbuf_q[sidx_m1[3:0]];
		oq_ctl.release_step = (state_q == ST_REL);
	end

	// coding sequencer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= ST_CLR;
			clr_idx_q  <= '0;
			wp_q       <= WSTART;
			la_q       <= '0;
			skip_q     <= '0;
			flags_q    <= '0;
			gunits_q   <= '0;
			gfill_q    <= '0;
			send_idx_q <= '0;
			end_q      <= 1'b0;
			drain_q    <= 1'b0;
			flush_q    <= 1'b0;
			cand_q     <= '0;
			d_q        <= '0;
			n_q        <= '0;
			best_q     <= '0;
			bpos_q     <= '0;
			limit_q    <= '0;
		end else begin
			unique case (state_q)
				ST_CLR: begin
					if (clr_idx_q == WLAST) begin
						clr_idx_q <= '0;
						wp_q      <= WSTART;
						la_q      <= '0;
						skip_q    <= '0;
						state_q   <= ST_IDLE;
					end else begin
						clr_idx_q <= clr_idx_q + 1'b1;
					end
				end
				ST_IDLE: begin
					if (accept) begin
						end_q   <= item.end_of_stream;
						drain_q <= 1'b0;
						if (la_q < MAXL)
							la_q <= la_q + 1'b1;
						state_q <= ST_CHK;
					end
				end
				ST_CHK: begin
					if (unit_due) begin
						if (skip_q == '0) begin
							limit_q <= (la_q < CAPL) ? la_q : CAPL;
							best_q  <= '0;
							bpos_q  <= '0;
							cand_q  <= (wp_q == '0) ? WLAST : wp_q - 1'b1;
							d_q     <= AW'(1);
							n_q     <= '0;
							state_q <= ST_ISS;
						end else begin
							state_q <= drain_q ? ST_ADVC : ST_ADV;
						end
					end else if (end_q && !drain_q) begin
						drain_q <= 1'b1;
					end else if (drain_q && gunits_q != '0) begin
						flush_q    <= 1'b1;
						send_idx_q <= '0;
						state_q    <= ST_SEND;
					end else begin
						state_q <= ST_REL;
					end
				end
				ST_ISS: begin
					state_q <= ST_EVAL;
				end
				ST_EVAL: begin
					if (hit && hit_len != limit_q) begin
						n_q     <= hit_len;
						state_q <= ST_ISS;
					end else begin
						best_q <= new_best;
						if (hit_len > best_q)
							bpos_q <= cand_q;
						if (d_q == WLAST || new_best >= limit_q) begin
							state_q <= ST_EMIT;
						end else begin
							d_q     <= d_q + 1'b1;
							cand_q  <= (cand_q == '0) ? WLAST : cand_q - 1'b1;
							n_q     <= '0;
							state_q <= ST_ISS;
						end
					end
				end
				ST_EMIT: begin
					if (best_q <= MINL) begin
						flags_q[gunits_q] <= 1'b1;
						if (gfill_q < 5'd16)
							gfill_q <= gfill_q + 1'b1;
						skip_q <= LEN_W'(1);
					end else begin
						if (gfill_q <= 5'd14)
							gfill_q <= gfill_q + 5'd2;
						skip_q <= best_q;
					end
					gunits_q <= gunits_q + 1'b1;
					if (gunits_q == 3'd7) begin
						flush_q    <= 1'b0;
						send_idx_q <= '0;
						state_q    <= ST_SEND;
					end else begin
						state_q <= drain_q ? ST_ADVC : ST_ADV;
					end
				end
				ST_SEND: begin
					if (send_idx_q == gfill_q) begin
						flags_q  <= '0;
						gfill_q  <= '0;
						gunits_q <= '0;
						if (flush_q)
							state_q <= ST_REL;
						else
							state_q <= drain_q ? ST_ADVC : ST_ADV;
					end else begin
						send_idx_q <= send_idx_q + 1'b1;
					end
				end
				ST_ADVC: begin
					state_q <= ST_ADV;
				end
				ST_ADV: begin
					wp_q <= (wp_q == WLAST) ? '0 : wp_q + 1'b1;
					if (la_q != '0)
						la_q <= la_q - 1'b1;
					if (skip_q != '0)
						skip_q <= skip_q - 1'b1;
					state_q <= ST_CHK;
				end
				ST_REL: begin
					state_q <= end_q ? ST_CLR : ST_IDLE;
				end
				default: begin
					state_q <= ST_CLR;
				end
			endcase
		end
	end

	lzss_oq u_oq (
		.clk        (clk),
		.arst_n     (arst_n),
		.ctl        (oq_ctl),
		.room       (oq_room),
		.code_valid (code_valid),
		.code_stall (code_stall),
		.code       (code)
	);

endmodule

FILE: design/lzss_chk.sv
// ----------------------------------------------------------------------------
// LZSS encoder port checker
// Watches the top-level channels over time; bound to the encoder core.
// ----------------------------------------------------------------------------
`include "lzss_stream_encoder_core_assert.svh"

module lzss_chk
	import lzss_pkg::*;
(
	input logic      clk,
	input logic      arst_n,
	input logic      item_valid,
	input logic      item_stall,
	input lzss_in_t  item,
	input logic      code_valid,
	input logic      code_stall,
	input lzss_out_t code
);

	// hold a stalled output transaction
	`LZSS_ASSERT_NEXT(a_code_hold, code_valid && code_stall, code_valid, "code valid dropped under stall")

	// the engine works on one byte at a time
	`LZSS_ASSERT_NEXT(a_one_item, item_valid && !item_stall, item_stall, "input taken twice in a row")

	// the output register refills only after a queue read
	`LZSS_ASSERT_NEXT(a_out_gap, code_valid && !code_stall, !code_valid, "output refilled without read")

	// a byte is never taken while any of its bits, stream end included, are unknown
	`LZSS_ASSERT_NOW(a_item_known, item_valid && !item_stall, !$isunknown(item), "unknown input taken")

endmodule

bind lzss_stream_encoder_core lzss_chk u_lzss_chk (.*);

FILE: tb/lzss_stream_encoder_core_test.sv
// ----------------------------------------------------------------------------
// LZSS stream encoder testbench
// Drives byte streams into the encoder and checks the code stream. A directed
// table comes first: single-byte streams, a run of spaces and a repeating
// pattern. Random streams with small alphabets and with full-range bytes
// follow. Code bytes are checked against a cycle-free software encoder, typed rows against the table.
// ----------------------------------------------------------------------------
module lzss_stream_encoder_core_test;
	import lzss_pkg::*;

	timeunit 1ns;
	timeprecision 1ps;

	localparam int WIN      = 4096;
	localparam int MAXM     = 18;
	localparam int MINM1    = 2;
	localparam int BURST    = 29;
	localparam int QCAP     = 64;
	localparam int N_RANDOM = 118;
	localparam int HOLD_CYC = 1500000;
	localparam int WD_LIMIT = 10000000;

	typedef struct {
		logic [7:0] data_byte;
		logic       eos;
		bit         typed;
		logic [7:0] exp_flag;
		logic [7:0] exp_lit;
	} dir_row_t;

	// Directed table: typed rows are single-byte streams from a clean state
	localparam int N_DIR = 22;
	dir_row_t dir_rows [N_DIR] = '{
		'{8'h41, 1'b1, 1'b1, 8'h01, 8'h41},
		'{8'h00, 1'b1, 1'b1, 8'h01, 8'h00},
		'{8'hFF, 1'b1, 1'b1, 8'h01, 8'hFF},
		'{8'h20, 1'b0, 1'b0, 8'h00, 8'h00},
		'{8'h20, 1'b0, 1'b0, 8'h00, 8'h00},
		'{8'h20, 1'b0, 1'b0, 8'h00, 8'h00},
		'{8'h20, 1'b0, 1'b0, 8'h00, 8'h00},
		'{8'h20, 1'b0, 1'b0, 8'h00, 8'h00},
		'{8'h20, 1'b0, 1'b0, 8'h00, 8'h00},
		'{8'h20, 1'b0, 1'b0, 8'h00, 8'h00},
		'{8'h20, 1'b0, 1'b0, 8'h00, 8'h00},
		'{8'h20, 1'b0, 1'b0, 8'h00, 8'h00},
		'{8'h20, 1'b1, 1'b0, 8'h00, 8'h00},
		'{8'h41, 1'b0, 1'b0, 8'h00, 8'h00},
		'{8'h42, 1'b0, 1'b0, 8'h00, 8'h00},
		'{8'h43, 1'b0, 1'b0, 8'h00, 8'h00},
		'{8'h41, 1'b0, 1'b0, 8'h00, 8'h00},
		'{8'h42, 1'b0, 1'b0, 8'h00, 8'h00},
		'{8'h43, 1'b0, 1'b0, 8'h00, 8'h00},
		'{8'h41, 1'b0, 1'b0, 8'h00, 8'h00},
		'{8'h42, 1'b0, 1'b0, 8'h00, 8'h00},
		'{8'h43, 1'b1, 1'b0, 8'h00, 8'h00}
	};

	logic      clk;
	logic      arst_n;
	logic      item_valid;
	logic      item_stall;
	lzss_in_t  item;
	logic      code_valid;
	logic      code_stall;
	lzss_out_t code;

	lzss_stream_encoder_core dut (
		.clk        (clk),
		.arst_n     (arst_n),
		.item_valid (item_valid),
		.item_stall (item_stall),
		.item       (item),
		.code_valid (code_valid),
		.code_stall (code_stall),
		.code       (code)
	);

	// Encoder shadow state
	logic [7:0] win_ring [WIN+MAXM-1];
	bit         src_map [WIN];
	int         coding_pos;
	int         look_cnt;
	int         skip_cnt;
	logic [7:0] grp_flags;
	logic [7:0] grp_bytes [16];
	int         grp_fill;
	int         grp_units;
	logic [7:0] code_backlog [$];

	lzss_out_t  expected_codes [$];
	dir_row_t   stim_rows [$];
	int         errors;
	int         stall_pct;
	int         acc_idx;
	bit         hold_req;
	bit         accepted_any;

	always #5 clk = ~clk;

	function automatic logic [7:0] ring_byte(int p);
		return win_ring[p % WIN];
	endfunction

	task automatic clear_stream();
		for (int i = 0; i < WIN + MAXM - 1; i++) win_ring[i] = FILL_CHAR;
		for (int i = 0; i < WIN; i++) src_map[i] = 0;
		coding_pos = WIN - MAXM;
		for (int i = 1; i <= MAXM; i++) src_map[coding_pos - i] = 1;
		look_cnt = 0;
		skip_cnt = 0;
		grp_flags = 0;
		for (int i = 0; i < 16; i++) grp_bytes[i] = 0;
		grp_fill = 0;
		grp_units = 0;
	endtask

	task automatic backlog_put(logic [7:0] b);
		if (code_backlog.size() < QCAP) code_backlog.insert(code_backlog.size(), b);
	endtask

	task automatic send_group();
		backlog_put(grp_flags);
		for (int i = 0; i < grp_fill && i < 16; i++) backlog_put(grp_bytes[i]);
		grp_flags = 0;
		grp_fill = 0;
		grp_units = 0;
	endtask

	// Longest match among registered sources, nearest wins on a tie
	task automatic code_one_unit(output int len);
		int lim, best, best_pos, p, n;
		lim = (look_cnt < MAXM) ? look_cnt : MAXM;
		if (lim > MINM1 + 16) lim = MINM1 + 16;
		best = 0;
		best_pos = 0;
		for (int d = 1; d < WIN && best < lim; d++) begin
			p = (coding_pos + WIN - d) % WIN;
			if (!src_map[p]) continue;
			n = 0;
			while (n < lim && ring_byte(p + n) == ring_byte(coding_pos + n)) n++;
			if (n > best) begin
				best = n;
				best_pos = p;
			end
		end
		if (best <= MINM1) begin
			grp_flags |= 8'(1 << (grp_units & 7));
			if (grp_fill < 16) grp_bytes[grp_fill++] = ring_byte(coding_pos);
			len = 1;
		end else begin
			if (grp_fill + 2 <= 16) begin
				grp_bytes[grp_fill++] = best_pos[7:0];
				grp_bytes[grp_fill++] = 8'(((best_pos >> 4) & 'hF0) |
					((best - MINM1 - 1) & 'h0F));
			end
			len = best;
		end
		grp_units++;
		if (grp_units >= 8) send_group();
	endtask

	task automatic slide_window();
		src_map[coding_pos] = 1;
		coding_pos = (coding_pos + 1) % WIN;
		if (look_cnt > 0) look_cnt--;
		if (skip_cnt > 0) skip_cnt--;
	endtask

	// Advance the shadow encoder by one input byte; return this step's codes
	task automatic encode_byte(input lzss_in_t in_txn, output lzss_out_t step_out [$]);
		int pos, n;
		lzss_out_t code_txn;
		step_out = {};
		if (look_cnt < MAXM) begin
			pos = (coding_pos + look_cnt) % WIN;
			src_map[pos] = 0;
			win_ring[pos] = in_txn.data_byte;
			if (pos < MAXM - 1) win_ring[pos + WIN] = in_txn.data_byte;
			look_cnt++;
		end
		if (look_cnt == MAXM) begin
			if (skip_cnt == 0) code_one_unit(skip_cnt);
			slide_window();
		end
		if (in_txn.end_of_stream) begin
			while (look_cnt > 0) begin
				if (skip_cnt == 0) code_one_unit(skip_cnt);
				src_map[(coding_pos + MAXM) % WIN] = 0;
				slide_window();
			end
			if (grp_units > 0) send_group();
			clear_stream();
		end
		n = (code_backlog.size() < BURST) ? code_backlog.size() : BURST;
		for (int k = 0; k < n; k++) begin
			code_txn.code_byte = code_backlog[k];
			code_txn.last_byte = (k + 1 == n);
			step_out.insert(step_out.size(), code_txn);
		end
		for (int k = 0; k < n; k++) void'(code_backlog.pop_front());
	endtask

	// Build one random stream: mostly a small alphabet, sometimes full-range bytes
	task automatic add_random_stream(int len);
		logic [7:0] alpha [4];
		bit         wide;
		dir_row_t   row;
		wide = ($urandom_range(99) < 30);
		for (int i = 0; i < 4; i++)
			alpha[i] = ($urandom_range(3) == 0) ? FILL_CHAR : 8'($urandom);
		for (int i = 0; i < len; i++) begin
			row.data_byte = wide ? 8'($urandom) : alpha[$urandom_range(3)];
			row.eos       = (i == len - 1);
			row.typed     = 1'b0;
			row.exp_flag  = 8'h00;
			row.exp_lit   = 8'h00;
			stim_rows.insert(stim_rows.size(), row);
		end
	endtask

	// Predict and check at each handshake
	always @(posedge clk) begin
		lzss_out_t step_out [$];
		lzss_out_t want;
		lzss_out_t typed_out;
		accepted_any = 0;
		if (arst_n) begin
			if (item_valid && !item_stall) begin
				accepted_any = 1;
				encode_byte(item, step_out);
				// Typed rows carry their codes in the table
				if (acc_idx < stim_rows.size() && stim_rows[acc_idx].typed) begin
					step_out = {};
					typed_out.code_byte = stim_rows[acc_idx].exp_flag;
					typed_out.last_byte = 1'b0;
					step_out.insert(0, typed_out);
					typed_out.code_byte = stim_rows[acc_idx].exp_lit;
					typed_out.last_byte = 1'b1;
					step_out.insert(1, typed_out);
				end
				acc_idx++;
				foreach (step_out[i]) expected_codes.insert(expected_codes.size(), step_out[i]);
			end
			if (code_valid && !code_stall) begin
				accepted_any = 1;
				if (expected_codes.size() == 0) begin
					errors++;
					$display("%0t: unexpected code %h last %b", $time,
						code.code_byte, code.last_byte);
				end else begin
					want = expected_codes.pop_front();
					if (want.code_byte !== code.code_byte ||
						want.last_byte !== code.last_byte) begin
						errors++;
						$display("%0t: expected code %h last %b, got %h last %b", $time,
							want.code_byte, want.last_byte, code.code_byte, code.last_byte);
					end
				end
			end
		end
	end

	// Receiver: random stalls, with one long hold-off on request
	initial begin
		code_stall = 1'b0;
		forever begin
			@(posedge clk);
			if (hold_req) begin
				code_stall <= 1'b1;
				repeat (HOLD_CYC) @(posedge clk);
				hold_req = 0;
			end
			code_stall <= ($urandom_range(99) < stall_pct);
		end
	end

	// Watchdog on cycles with no transaction on either side
	initial begin
		int idle_cyc;
		idle_cyc = 0;
		forever begin
			@(posedge clk);
			#1;
			idle_cyc = accepted_any ? 0 : idle_cyc + 1;
			if (idle_cyc >= WD_LIMIT) begin
				$display("FAILED: results differ");
				$finish;
			end
		end
	end

	// Sender
	initial begin
		int idx, nrows, send_pct, phase, slen, rows_left;
		clk = 1'b0;
		arst_n = 1'b0;
		item_valid = 1'b0;
		item = '0;
		errors = 0;
		stall_pct = 0;
		acc_idx = 0;
		hold_req = 0;
		accepted_any = 0;
		clear_stream();
		foreach (dir_rows[i]) stim_rows.insert(stim_rows.size(), dir_rows[i]);
		while (stim_rows.size() < N_DIR + N_RANDOM) begin
			slen = ($urandom_range(9) == 0) ? $urandom_range(30, 60)
				: $urandom_range(1, 25);
			rows_left = N_DIR + N_RANDOM - stim_rows.size();
			if (slen > rows_left) slen = rows_left;
			add_random_stream(slen);
		end
		nrows = stim_rows.size();
		repeat (2) @(posedge clk);
		arst_n <= 1'b1;

		idx = 0;
		while (idx < nrows || item_valid) begin
			@(posedge clk);
			if (item_valid && item_stall) continue;
			if (item_valid) begin
				idx++;
				if (idx == 25) hold_req = 1;
				if (idx == 110) begin
					// Pause until the code stream catches up
					item_valid <= 1'b0;
					while (expected_codes.size() > 0) @(posedge clk);
				end
			end
			phase = (idx * 4) / nrows;
			send_pct = (phase == 1) ? 54 : (phase == 3) ? 23 : 0;
			stall_pct = (phase == 2) ? 54 : (phase == 3) ? 23 : 0;
			if (idx < nrows && $urandom_range(99) >= send_pct) begin
				item_valid <= 1'b1;
				item <= '{data_byte: stim_rows[idx].data_byte,
					end_of_stream: stim_rows[idx].eos};
			end else begin
				item_valid <= 1'b0;
			end
		end

		// Flush any backlog past the burst limit with single-byte streams
		while (code_backlog.size() > 0) begin
			item_valid <= 1'b1;
			item <= '{data_byte: 8'($urandom), end_of_stream: 1'b1};
			do @(posedge clk); while (item_stall);
			item_valid <= 1'b0;
			@(posedge clk);
		end
		item_valid <= 1'b0;

		while (expected_codes.size() > 0) @(posedge clk);
		repeat (200) @(posedge clk);
		if (errors == 0)
			$display("PASSED: all results match");
		else
			$display("FAILED: results differ");
		$finish;
	end

endmodule

FILE: files.f
+incdir+design
design/lzss_pkg.sv
design/lzss_oq.sv
design/lzss_stream_encoder_core.sv
design/lzss_chk.sv
tb/lzss_stream_encoder_core_test.sv
